>>> sv/iprf_pkg.sv
// Package for the integer polynomial root finder.
// Holds the coefficient and root types and the shared arithmetic result type.
// No dependencies.
package iprf_pkg;

   // Width of one incoming coefficient
   localparam int IN_W = 16;
   // Width of the stored coefficients and the Horner accumulator
   localparam int COEF_W = 64;
   // Width of a root, which is also the width of a search candidate
   localparam int ROOT_W = 7;
   // Full width of accumulator times candidate
   localparam int PROD_W = COEF_W + ROOT_W;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [ROOT_W-1:0] root_type;

   // Result of one multiply-add step
   typedef struct packed {
      coef_type sum;
      logic     ovf;
   } mac_result_type;

endpackage

>>> sv/iprf_mac.sv
// Shared multiply-add unit: acc * mult + addend, wrapped to 64 bits.
// Flags a product or a sum that leaves the signed 64-bit range.
// Depends on iprf_pkg.
module iprf_mac (
   input  iprf_pkg::coef_type       acc,
   input  iprf_pkg::root_type       mult,
   input  iprf_pkg::coef_type       addend,
   output iprf_pkg::mac_result_type result
);
   import iprf_pkg::*;

   logic signed [PROD_W-1:0] prod;
   coef_type                 prod_wrap;
   coef_type                 sum;
   logic                     mul_ovf;
   logic                     add_ovf;

   // exact product; it fits only if the top bits all copy the sign
   assign prod      = PROD_W'(acc) * PROD_W'(mult);
   assign prod_wrap = prod[COEF_W-1:0];
   assign mul_ovf   = !((&prod[PROD_W-1:COEF_W-1]) || !(|prod[PROD_W-1:COEF_W-1]));

   // wrapped add with signed overflow check
   assign sum     = prod_wrap + addend;
   assign add_ovf = (prod_wrap[COEF_W-1] == addend[COEF_W-1])
                    && (sum[COEF_W-1] != prod_wrap[COEF_W-1]);

   assign result.sum = sum;
   assign result.ovf = mul_ovf || add_ovf;

endmodule

>>> sv/integer_polynomial_root_finder_unit.sv
// Channel   | Ports                                           | Handshake
// ----------+-------------------------------------------------+---------------------------
// request   | req_coefficient, req_last_coefficient           | start && !busy
// result    | rsp_root, rsp_has_root, rsp_overflow,           | rsp_valid, one cycle each
//           | rsp_last_result                                 |
//
// A coefficient request without the last mark is stored while there is room; busy stays low.
// On the last coefficient the sequencer runs the search on the one shared multiply-add
// unit: each candidate is one Horner evaluation over the degree, each root found is
// followed by a deflation, with up to SEARCH_TRIES candidates per pass, over up to
// MAX_DEGREE passes, then the results are emitted. busy is high the whole time.
// Reset is synchronous and clears all control state; the receiver cannot stall.
// Depends on iprf_pkg and iprf_mac.
module integer_polynomial_root_finder_unit #(
   parameter int MAX_DEGREE   = 8,
   parameter int SEARCH_TRIES = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [iprf_pkg::IN_W-1:0]  req_coefficient,
   input  logic                              req_last_coefficient,
   output logic                              busy,
   output logic                              rsp_valid,
   output iprf_pkg::root_type                rsp_root,
   output logic                              rsp_has_root,
   output logic                              rsp_overflow,
   output logic                              rsp_last_result
);
   import iprf_pkg::*;

   localparam int DEPTH  = MAX_DEGREE + 1;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int RIX_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int CAND_W = $clog2(SEARCH_TRIES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND_INIT,
      ST_EVAL,
      ST_DEFL_INIT,
      ST_DEFL,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   deg_ff, deg_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [CAND_W-1:0]  cand_ff, cand_in;
   coef_type           acc_ff, acc_in;
   logic               ovf_loc_ff, ovf_loc_in;
   logic               ovf_seen_ff, ovf_seen_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   emit_ff, emit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   root_type           rsp_root_ff, rsp_root_in;
   logic               rsp_has_root_ff, rsp_has_root_in;
   logic               rsp_overflow_ff, rsp_overflow_in;
   logic               rsp_last_result_ff, rsp_last_result_in;
   coef_type           rd_ff;

   coef_type           coef_store [DEPTH];
   root_type           root_buf [MAX_DEGREE];

   logic               accept;
   logic               room;
   coef_type           coef_ext;
   coef_type           rd_data;
   logic [ROOT_W-1:0]  cand_ext;
   root_type           cand_mag;
   root_type           cand_z;
   mac_result_type     mac;
   logic               root_found;
   logic               defl_wr;

   assign accept = start && !busy;
   assign room   = cnt_ff < CNT_W'(DEPTH);
   assign busy   = state_ff != ST_IDLE;

   assign coef_ext = {{(COEF_W - IN_W){req_coefficient[IN_W-1]}}, req_coefficient};
   // registered read, addressed by the next pointer so that it matches the current pointer
   assign rd_data  = rd_ff;

   // candidate order 0, 0, -1, 1, -2, 2, ...
   assign cand_ext = ROOT_W'(cand_ff);
   assign cand_mag = root_type'(cand_ext >> 1);
   assign cand_z   = cand_ext[0] ? cand_mag : -cand_mag;

   iprf_mac u_mac (
      .acc    (acc_ff),
      .mult   (cand_z),
      .addend (rd_data),
      .result (mac)
   );

   // last Horner step of a candidate with an exact zero
   assign root_found = (state_ff == ST_EVAL) && (ptr_ff == deg_ff)
                       && !(ovf_loc_ff || mac.ovf) && (mac.sum == '0);
   assign defl_wr    = (state_ff == ST_DEFL) && (ptr_ff != deg_ff);

   // sequencer next state
   always_comb begin
      logic [IDX_W-1:0] deg_new;
      deg_new            = room ? IDX_W'(cnt_ff) : IDX_W'(MAX_DEGREE);
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      deg_in             = deg_ff;
      ptr_in             = ptr_ff;
      cand_in            = cand_ff;
      acc_in             = acc_ff;
      ovf_loc_in         = ovf_loc_ff;
      ovf_seen_in        = ovf_seen_ff;
      n_in               = n_ff;
      emit_in            = emit_ff;
      rsp_valid_in       = 1'b0;
      rsp_root_in        = rsp_root_ff;
      rsp_has_root_in    = rsp_has_root_ff;
      rsp_overflow_in    = rsp_overflow_ff;
      rsp_last_result_in = rsp_last_result_ff;
      case (state_ff)
         ST_IDLE: begin
            emit_in = '0;
            if (accept) begin
               if (room) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_last_coefficient) begin
                  cnt_in      = '0;
                  deg_in      = deg_new;
                  ovf_seen_in = 1'b0;
                  n_in        = '0;
                  cand_in     = '0;
                  ptr_in      = '0;
                  state_in    = (deg_new == '0) ? ST_EMIT : ST_CAND_INIT;
               end
            end
         end
         ST_CAND_INIT: begin
            acc_in     = rd_data;
            ptr_in     = IDX_W'(1);
            ovf_loc_in = 1'b0;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            if (ptr_ff == deg_ff) begin
               if (ovf_loc_ff || mac.ovf) begin
                  ovf_seen_in = 1'b1;
               end
               ptr_in = '0;
               if (root_found) begin
                  n_in     = n_ff + IDX_W'(1);
                  state_in = ST_DEFL_INIT;
               end else if (cand_ff == CAND_W'(SEARCH_TRIES - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  cand_in  = cand_ff + CAND_W'(1);
                  state_in = ST_CAND_INIT;
               end
            end else begin
               acc_in     = mac.sum;
               ovf_loc_in = ovf_loc_ff || mac.ovf;
               ptr_in     = ptr_ff + IDX_W'(1);
            end
         end
         ST_DEFL_INIT: begin
            acc_in   = rd_data;
            ptr_in   = IDX_W'(1);
            state_in = ST_DEFL;
         end
         ST_DEFL: begin
            if (ptr_ff == deg_ff) begin
               deg_in = deg_ff - IDX_W'(1);
               if (deg_ff == IDX_W'(1)) begin
                  state_in = ST_EMIT;
               end else begin
                  cand_in  = '0;
                  ptr_in   = '0;
                  state_in = ST_CAND_INIT;
               end
            end else begin
               acc_in = mac.sum;
               ptr_in = ptr_ff + IDX_W'(1);
               if (mac.ovf) begin
                  ovf_seen_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_has_root_in    = n_ff != '0;
            rsp_root_in        = (n_ff != '0) ? root_buf[emit_ff[RIX_W-1:0]] : '0;
            rsp_overflow_in    = ovf_seen_ff;
            rsp_last_result_in = (n_ff == '0) || (emit_ff == n_ff - IDX_W'(1));
            if (rsp_last_result_in) begin
               state_in = ST_IDLE;
            end else begin
               emit_in = emit_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         deg_ff       <= '0;
         ptr_ff       <= '0;
         cand_ff      <= '0;
         ovf_loc_ff   <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         n_ff         <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff           <= state_in;
         cnt_ff             <= cnt_in;
         deg_ff             <= deg_in;
         ptr_ff             <= ptr_in;
         cand_ff            <= cand_in;
         ovf_loc_ff         <= ovf_loc_in;
         ovf_seen_ff        <= ovf_seen_in;
         n_ff               <= n_in;
         emit_ff            <= emit_in;
         rsp_valid_ff       <= rsp_valid_in;
         acc_ff             <= acc_in;
         rsp_root_ff        <= rsp_root_in;
         rsp_has_root_ff    <= rsp_has_root_in;
         rsp_overflow_ff    <= rsp_overflow_in;
         rsp_last_result_ff <= rsp_last_result_in;
      end
   end

   // coefficient store: load on request, rewrite during deflation, read at the next pointer
   always_ff @(posedge clock) begin
      if (accept && room) begin
         coef_store[cnt_ff[IDX_W-1:0]] <= coef_ext;
      end else if (defl_wr) begin
         coef_store[ptr_ff] <= mac.sum;
      end
      rd_ff <= coef_store[ptr_in];
   end

   // roots found, held until the search ends
   always_ff @(posedge clock) begin
      if (root_found) begin
         root_buf[n_ff[RIX_W-1:0]] <= cand_z;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root        = rsp_root_ff;
   assign rsp_has_root    = rsp_has_root_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_last_result = rsp_last_result_ff;

   // a result only ever follows a cycle in the output state
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_EMIT))
      else $error("result strobe without output state");

   // Horner and deflation pointers stay within the current degree
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL || state_ff == ST_DEFL) |-> (ptr_ff != '0 && ptr_ff <= deg_ff))
      else $error("coefficient pointer out of range");

   // a candidate starts only on a live polynomial, reading the leading coefficient
   a_cand_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CAND_INIT) |-> (deg_ff != '0 && ptr_ff == '0))
      else $error("candidate started with zero degree or stale pointer");

   // the final result ends the run
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_result_ff) |-> (state_ff == ST_IDLE) ##1 !rsp_valid_ff)
      else $error("results continue after the final one");

   // never more roots than the largest degree
   a_root_count: assert property (@(posedge clock) disable iff (reset)
      n_ff <= IDX_W'(MAX_DEGREE))
      else $error("root count beyond maximum degree");

endmodule

>>> tb/integer_polynomial_root_finder_unit_tb.sv
// Testbench for integer_polynomial_root_finder_unit: feeds coefficient requests, predicts
// the integer roots with its own exact Horner search and checks every strobed result.
// Depends on iprf_pkg and the unit under test only.
`timescale 1ns / 1ps

module integer_polynomial_root_finder_unit_tb;
   import iprf_pkg::*;

   localparam int MAX_DEGREE   = 8;
   localparam int SEARCH_TRIES = 100;
   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS = 76;

   // One expected result of a polynomial
   typedef struct packed {
      root_type root;
      logic     has_root;
      logic     overflow;
      logic     last_result;
   } root_rsp_type;

   // One row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic signed [IN_W-1:0] coef;
      logic                   last;
      logic                   typed;
      root_rsp_type           want;
   } dir_row_type;

   localparam root_rsp_type NO_ROOT = '{7'sd0, 1'b0, 1'b0, 1'b1};

   localparam dir_row_type DIRECTED [24] = '{
      // single coefficient: degree zero, nothing to search
      '{16'sd5, 1'b1, 1'b1, NO_ROOT},
      '{-16'sd32768, 1'b1, 1'b1, NO_ROOT},
      // x: root zero on the very first candidate
      '{16'sd1, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b1, 1'b1, '{7'sd0, 1'b1, 1'b0, 1'b1}},
      // x - 49 and x + 49: the outermost candidates
      '{16'sd1, 1'b0, 1'b0, '0},
      '{-16'sd49, 1'b1, 1'b1, '{7'sd49, 1'b1, 1'b0, 1'b1}},
      '{16'sd1, 1'b0, 1'b0, '0},
      '{16'sd49, 1'b1, 1'b1, '{-7'sd49, 1'b1, 1'b0, 1'b1}},
      // largest positive coefficients, root -1
      '{16'sd32767, 1'b0, 1'b0, '0},
      '{16'sd32767, 1'b1, 1'b1, '{-7'sd1, 1'b1, 1'b0, 1'b1}},
      // x^2 - 1: two roots with deflation in between
      '{16'sd1, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{-16'sd1, 1'b1, 1'b0, '0},
      // x^8 then two surplus coefficients, which are dropped apart from the last mark
      '{16'sd1, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b0, 1'b0, '0},
      '{16'sd7, 1'b0, 1'b0, '0},
      '{16'sd9, 1'b1, 1'b0, '0}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic signed [IN_W-1:0] req_coefficient;
   logic                   req_last_coefficient;
   logic                   busy;
   logic                   rsp_valid;
   root_type               rsp_root;
   logic                   rsp_has_root;
   logic                   rsp_overflow;
   logic                   rsp_last_result;

   // Predictor state
   coef_type     poly_store [MAX_DEGREE+1];
   int           stored_count;
   root_rsp_type predicted_roots [$];
   root_rsp_type expected_roots [$];

   longint poly_coefs [$];
   int     burst_left;
   int     random_items;
   int     fail_count = 0;
   int     idle_cycles = 0;

   integer_polynomial_root_finder_unit #(
      .MAX_DEGREE  (MAX_DEGREE),
      .SEARCH_TRIES(SEARCH_TRIES)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_coefficient     (req_coefficient),
      .req_last_coefficient(req_last_coefficient),
      .busy                (busy),
      .rsp_valid           (rsp_valid),
      .rsp_root            (rsp_root),
      .rsp_has_root        (rsp_has_root),
      .rsp_overflow        (rsp_overflow),
      .rsp_last_result     (rsp_last_result)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Wrapping 64-bit multiply with signed range check
   function automatic coef_type mul_wrap(input coef_type a, input coef_type b, output bit o);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] p;
      wa = a;
      wb = b;
      p  = wa * wb;
      o  = (p[127:63] != {65{p[63]}});
      return p[63:0];
   endfunction

   // Wrapping 64-bit add with signed range check
   function automatic coef_type add_wrap(input coef_type a, input coef_type b, output bit o);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      o = (s[64] != s[63]);
      return s[63:0];
   endfunction

   // Search order 0, 0, -1, 1, -2, 2 ...
   function automatic coef_type candidate_of(input int i);
      coef_type m;
      m = coef_type'(i >> 1);
      return (i & 1) ? m : -m;
   endfunction

   // Stores one coefficient; on the last mark runs the root search and deflation
   task automatic predict_roots(input logic signed [IN_W-1:0] c, input logic l);
      coef_type acc, z, nxt, prod;
      bit       o1, o2, ovf, ovf_seen, found;
      int       deg;
      root_type roots [$];
      predicted_roots.delete();
      if (stored_count < MAX_DEGREE + 1) begin
         poly_store[stored_count] = c;
         stored_count++;
      end
      if (!l) return;
      deg      = stored_count - 1;
      ovf_seen = 1'b0;
      while (deg >= 1) begin
         found = 1'b0;
         z     = '0;
         for (int i = 0; i < SEARCH_TRIES && !found; i++) begin
            z   = candidate_of(i);
            ovf = 1'b0;
            acc = poly_store[0];
            for (int x = 1; x <= deg; x++) begin
               prod = mul_wrap(acc, z, o1);
               acc  = add_wrap(prod, poly_store[x], o2);
               ovf  = ovf | o1 | o2;
            end
            if (ovf) ovf_seen = 1'b1;
            else if (acc == 0) found = 1'b1;
         end
         if (!found) break;
         roots.push_back(root_type'(z));
         // synthetic division by (x - z)
         ovf = 1'b0;
         nxt = poly_store[0];
         for (int x = 0; x < deg; x++) begin
            poly_store[x] = nxt;
            prod = mul_wrap(poly_store[x], z, o1);
            nxt  = add_wrap(poly_store[x+1], prod, o2);
            ovf  = ovf | o1 | o2;
         end
         if (ovf) ovf_seen = 1'b1;
         deg--;
      end
      stored_count = 0;
      if (roots.size() == 0)
         predicted_roots.push_back('{7'sd0, 1'b0, ovf_seen, 1'b1});
      foreach (roots[k])
         predicted_roots.push_back('{roots[k], 1'b1, ovf_seen, k == roots.size() - 1});
   endtask

   // Drives one request in bursts with random gaps, then records what it should produce
   task automatic send_coef(input logic signed [IN_W-1:0] c, input logic l,
                            input logic typed, input root_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         @(negedge clock);
         start <= 1'b0;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = $urandom_range(0, 2);
            6, 7, 8:          gap = $urandom_range(3, 11);
            default:          gap = $urandom_range(30, 80);
         endcase
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      end
      @(negedge clock);
      start                <= 1'b1;
      req_coefficient      <= c;
      req_last_coefficient <= l;
      do @(posedge clock); while (busy);
      burst_left--;
      predict_roots(c, l);
      if (typed && l) expected_roots.push_back(want);
      else foreach (predicted_roots[k]) expected_roots.push_back(predicted_roots[k]);
   endtask

   task automatic send_poly();
      foreach (poly_coefs[i])
         send_coef(IN_W'(poly_coefs[i]), i == poly_coefs.size() - 1, 1'b0, '0);
      random_items += poly_coefs.size();
   endtask

   // Multiplies out lead * (x - r1) ... (x - rd) until every coefficient fits 16 bits
   task automatic build_factored_poly();
      int     deg, span;
      longint lead, r;
      longint p [$];
      bit     fits;
      do begin
         deg  = $urandom_range(1, MAX_DEGREE);
         span = (deg <= 2) ? 60 : (deg <= 4) ? 9 : 3;
         lead = $urandom_range(1, 3);
         if ($urandom_range(0, 1)) lead = -lead;
         poly_coefs = '{lead};
         for (int k = 0; k < deg; k++) begin
            r = longint'($urandom_range(0, 2 * span)) - span;
            p = poly_coefs;
            poly_coefs.push_back(0);
            for (int j = 1; j < poly_coefs.size(); j++)
               poly_coefs[j] = poly_coefs[j] - r * p[j-1];
         end
         fits = 1'b1;
         foreach (poly_coefs[j])
            if (poly_coefs[j] > 32767 || poly_coefs[j] < -32768) fits = 1'b0;
      end while (!fits);
   endtask

   // Result checker
   always @(posedge clock) begin : check_results
      root_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_roots.size() == 0) begin
            $display("%0t: unexpected result root=%0d has_root=%0b", $time,
                     $signed(rsp_root), rsp_has_root);
            fail_count++;
         end else begin
            want = expected_roots.pop_front();
            if (rsp_root !== want.root) begin
               $display("%0t: root expected %0d, got %0d", $time,
                        $signed(want.root), $signed(rsp_root));
               fail_count++;
            end
            if (rsp_has_root !== want.has_root) begin
               $display("%0t: has_root expected %0b, got %0b", $time,
                        want.has_root, rsp_has_root);
               fail_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b, got %0b", $time,
                        want.overflow, rsp_overflow);
               fail_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $display("%0t: last_result expected %0b, got %0b", $time,
                        want.last_result, rsp_last_result);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: no request and no result taken for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                  IDLE_LIMIT, expected_roots.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int pick, j, delta;
      reset                = 1'b1;
      start                = 1'b0;
      req_coefficient      = '0;
      req_last_coefficient = 1'b0;
      stored_count         = 0;
      burst_left           = 0;
      random_items         = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (DIRECTED[i])
         send_coef(DIRECTED[i].coef, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

      // Hold off until the block has drained
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (expected_roots.size() != 0) @(posedge clock);

      // Random polynomials: mostly built from known roots, some noise, some near misses
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            build_factored_poly();
         end else if (pick <= 8) begin
            poly_coefs.delete();
            repeat ($urandom_range(1, MAX_DEGREE + 3))
               poly_coefs.push_back(longint'($signed(16'($urandom))));
         end else begin
            build_factored_poly();
            j     = $urandom_range(0, poly_coefs.size() - 1);
            delta = $urandom_range(1, 3);
            if (poly_coefs[j] + delta > 32767) poly_coefs[j] = poly_coefs[j] - delta;
            else poly_coefs[j] = poly_coefs[j] + delta;
         end
         send_poly();
      end

      // Drain, then allow a short quiet period for stray results
      @(negedge clock);
      start <= 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
